>>> rtl/core/dct2d_pkg.sv
// Package for the 2-D DCT / IDCT block: sequencer states, pipeline tag and
// fixed data widths. No dependencies.
`default_nettype none

package dct2d_pkg;

  localparam int SAMPLE_W  = 16;  // input sample / coefficient
  localparam int PART_W    = 24;  // first-pass intermediate
  localparam int OUT_W     = 16;  // final result
  localparam int PART_FRAC = 4;   // fraction bits kept in the intermediate

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COL,
    ST_COL_DRAIN,
    ST_ROW,
    ST_ROW_DRAIN
  } dct2d_state_t;

  // Travels alongside each product through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;      // first term of a dot product
    logic last;       // last term of a dot product
    logic row_phase;  // 0: column pass, 1: row pass
  } mac_tag_t;

endpackage

`default_nettype wire

>>> rtl/core/block_dct_idct_2d.sv
// Top level of the 2-D orthonormal DCT-II / inverse DCT on square blocks.
// Uses dct2d_pkg, dct2d_coef_rom and dct2d_mac.
//
//  channel  | ports                               | transaction
//  ---------+-------------------------------------+-------------------------------
//  input    | in_valid/in_ready, in_sample_value  | one sample, row-major
//  output   | out_valid/out_ready, out_value,     | one transformed value,
//           | out_block_last                      | row-major, last flags end
//  config   | cfg_wr_en, cfg_wr_data              | direction: 0 fwd, 1 inverse
//
// A block loads in BLOCK_SIZE^2 transactions (one per cycle at most), then the
// single MAC runs 2*BLOCK_SIZE^3 products, and each pass ends with a pipeline
// drain. The shared multiplier and the one read port of each store limit the
// throughput. in_ready is high only while the block is loading. Reset clears
// the sequencer, counters and valid flags; the sample and intermediate stores
// are not cleared. A held result (out_valid high, out_ready low) freezes the
// whole MAC pipeline.
`default_nettype none

module block_dct_idct_2d #(
  parameter int BLOCK_SIZE     = 8,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [dct2d_pkg::SAMPLE_W-1:0]    in_sample_value,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [dct2d_pkg::OUT_W-1:0]            out_value,
  output logic                                          out_block_last,
  input  wire logic                                     cfg_wr_en,
  input  wire logic                                     cfg_wr_data
);

  import dct2d_pkg::*;

  localparam int NSQ    = BLOCK_SIZE * BLOCK_SIZE;
  localparam int AW     = $clog2(NSQ);
  localparam int IW     = $clog2(BLOCK_SIZE);
  localparam int RW     = $clog2(NSQ + 1);
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int ACC_W  = PART_W + COEF_W + IW + 1;

  localparam logic [IW-1:0] LAST_IDX  = IW'(BLOCK_SIZE - 1);
  localparam logic [AW-1:0] LAST_LOAD = AW'(NSQ - 1);
  localparam logic [RW-1:0] RES_ALL   = RW'(NSQ);
  localparam logic [RW-1:0] RES_LAST  = RW'(NSQ - 1);

  dct2d_state_t state_r;
  dct2d_state_t state_nxt;

  logic                        direction_r;
  logic                        inv_r;
  logic [AW-1:0]               load_cnt_r;
  logic [IW-1:0]               a_r;
  logic [IW-1:0]               b_r;
  logic [IW-1:0]               i_r;
  logic [RW-1:0]               res_cnt_r;
  mac_tag_t                    tag1_r;
  mac_tag_t                    tag1_nxt;
  mac_tag_t                    tag3;

  logic signed [SAMPLE_W-1:0]  in_mem   [NSQ];
  logic signed [PART_W-1:0]    part_mem [NSQ];
  logic signed [SAMPLE_W-1:0]  in_rd_r;
  logic signed [PART_W-1:0]    part_rd_r;

  logic                        out_valid_r;
  logic signed [OUT_W-1:0]     out_value_r;
  logic                        out_block_last_r;

  logic                        in_accept;
  logic                        issuing;
  logic                        row_phase;
  logic                        adv;
  logic                        iss_end;
  logic                        done_now;
  logic                        emit;
  logic                        part_wr;
  logic [AW-1:0]               in_rd_addr;
  logic [AW-1:0]               part_rd_addr;
  logic [IW-1:0]               x_idx;
  logic [IW-1:0]               rom_row;
  logic [IW-1:0]               rom_col;
  logic signed [COEF_W-1:0]    coef;
  logic signed [PART_W-1:0]    mac_op;
  logic signed [PART_W-1:0]    part_sat;
  logic signed [OUT_W-1:0]     res_sat;

  // ---------------- sequencer ----------------
  always_comb begin
    in_ready  = 1'b0;
    issuing   = 1'b0;
    row_phase = 1'b0;
    case (state_r)
      ST_LOAD:      in_ready  = 1'b1;
      ST_COL:       issuing   = 1'b1;
      ST_COL_DRAIN: issuing   = 1'b0;
      ST_ROW: begin
        issuing   = 1'b1;
        row_phase = 1'b1;
      end
      ST_ROW_DRAIN: row_phase = 1'b1;
      default:      issuing   = 1'b0;
    endcase
  end

  assign in_accept = in_valid && in_ready;
  assign adv       = !out_valid_r || out_ready;
  assign iss_end   = (a_r == LAST_IDX) && (b_r == LAST_IDX) && (i_r == LAST_IDX);
  assign done_now  = adv && tag3.valid && tag3.last;
  assign emit      = done_now && tag3.row_phase;
  assign part_wr   = done_now && !tag3.row_phase;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_accept && (load_cnt_r == LAST_LOAD)) state_nxt = ST_COL;
      end
      ST_COL: begin
        if (adv && iss_end) state_nxt = ST_COL_DRAIN;
      end
      ST_COL_DRAIN: begin
        if (res_cnt_r == RES_ALL) state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (adv && iss_end) state_nxt = ST_ROW_DRAIN;
      end
      ST_ROW_DRAIN: begin
        if (res_cnt_r == RES_ALL) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      direction_r <= 1'b0;
      inv_r       <= 1'b0;
      load_cnt_r  <= '0;
      a_r         <= '0;
      b_r         <= '0;
      i_r         <= '0;
      res_cnt_r   <= '0;
      tag1_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        direction_r <= cfg_wr_data;
      end
      if (in_accept) begin
        if (load_cnt_r == LAST_LOAD) begin
          load_cnt_r <= '0;
          inv_r      <= direction_r;  // mode is fixed by the last sample
        end else begin
          load_cnt_r <= load_cnt_r + AW'(1);
        end
      end
      // walk a, b, i with i fastest
      if (adv && issuing) begin
        if (i_r == LAST_IDX) begin
          i_r <= '0;
          if (b_r == LAST_IDX) begin
            b_r <= '0;
            a_r <= (a_r == LAST_IDX) ? '0 : a_r + IW'(1);
          end else begin
            b_r <= b_r + IW'(1);
          end
        end else begin
          i_r <= i_r + IW'(1);
        end
      end
      if (adv) begin
        tag1_r <= tag1_nxt;
      end
      if ((state_r == ST_LOAD) ||
          ((state_r == ST_COL_DRAIN) && (res_cnt_r == RES_ALL))) begin
        res_cnt_r <= '0;
      end else if (done_now) begin
        res_cnt_r <= res_cnt_r + RW'(1);
      end
    end
  end

  always_comb begin
    tag1_nxt.valid     = issuing;
    tag1_nxt.first     = (i_r == '0);
    tag1_nxt.last      = (i_r == LAST_IDX);
    tag1_nxt.row_phase = row_phase;
  end

  // ---------------- stores ----------------
  assign in_rd_addr   = AW'(32'(i_r) * BLOCK_SIZE + 32'(b_r));
  assign part_rd_addr = AW'(32'(a_r) * BLOCK_SIZE + 32'(i_r));

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_mem[load_cnt_r] <= in_sample_value;
    end
    if (adv) begin
      in_rd_r <= in_mem[in_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (part_wr) begin
      part_mem[res_cnt_r[AW-1:0]] <= part_sat;
    end
    if (adv) begin
      part_rd_r <= part_mem[part_rd_addr];
    end
  end

  // ---------------- coefficient select ----------------
  // column pass uses C (or C^T), row pass uses C^T (or C); both swap on inv
  assign x_idx   = row_phase ? b_r : a_r;
  assign rom_row = inv_r ? i_r : x_idx;
  assign rom_col = inv_r ? x_idx : i_r;

  dct2d_coef_rom #(
    .BLOCK_SIZE     (BLOCK_SIZE),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .IW             (IW),
    .COEF_W         (COEF_W)
  ) u_rom (
    .clk     (clk),
    .en      (adv),
    .row_idx (rom_row),
    .col_idx (rom_col),
    .coef    (coef)
  );

  assign mac_op = tag1_r.row_phase ? part_rd_r : PART_W'(in_rd_r);

  dct2d_mac #(
    .COEF_W         (COEF_W),
    .ACC_W          (ACC_W),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .tag_in   (tag1_r),
    .op_in    (mac_op),
    .coef_in  (coef),
    .tag_out  (tag3),
    .part_sat (part_sat),
    .res_sat  (res_sat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r      <= res_sat;
      out_block_last_r <= (res_cnt_r == RES_LAST);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_block_last = out_block_last_r;

  // ---------------- assertions ----------------
  a_emit_in_row_pass: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (state_r == ST_ROW || state_r == ST_ROW_DRAIN))
    else $error("result emitted outside the row pass");

  a_part_wr_in_col_pass: assert property (@(posedge clk) disable iff (!rst_n)
    part_wr |-> (state_r == ST_COL || state_r == ST_COL_DRAIN))
    else $error("intermediate written outside the column pass");

  a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RES_ALL)
    else $error("completion count overran the block");

  a_pipe_empty_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (!tag1_r.valid && !tag3.valid))
    else $error("MAC pipeline busy while loading");

  // loading clears the completion count even while the last result waits
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && (state_r != ST_LOAD)) |=>
      ($stable(res_cnt_r) && $stable(i_r)))
    else $error("sequencer moved while a result was held");

endmodule

`default_nettype wire

>>> rtl/core/dct2d_coef_rom.sv
// Cosine coefficient ROM with registered read. The table is built at
// elaboration in fixed point from BLOCK_SIZE and COEF_FRAC_BITS. No package use.
`default_nettype none

module dct2d_coef_rom #(
  parameter int BLOCK_SIZE     = 8,
  parameter int COEF_FRAC_BITS = 14,
  parameter int IW             = $clog2(BLOCK_SIZE),
  parameter int COEF_W         = COEF_FRAC_BITS + 2
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [IW-1:0]            row_idx,
  input  wire logic [IW-1:0]            col_idx,
  output logic signed [COEF_W-1:0]      coef
);

  localparam int NSQ = BLOCK_SIZE * BLOCK_SIZE;
  localparam int AW  = $clog2(NSQ);
  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint PI_Q30  = 64'sd3373259426;

  typedef logic signed [COEF_W-1:0] tab_t [NSQ];

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned bt;
    v  = v_in;
    r  = 64'd0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // cos(pi*t/(2*BLOCK_SIZE)) in Q30 by a truncated Taylor series
  function automatic longint cos_q30(input int t);
    longint x;
    longint x2;
    longint r;
    x  = (PI_Q30 * longint'(t)) / (2 * BLOCK_SIZE);
    x2 = (x * x) / Q30_ONE;
    r  = Q30_ONE;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 380;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 306;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 240;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 182;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 132;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 90;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 56;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 30;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 12;
    r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 2;
    if (r < 0) r = 0;
    if (r > Q30_ONE) r = Q30_ONE;
    return r;
  endfunction

  localparam longint unsigned S0 = isqrt64((64'd1 << 60) / BLOCK_SIZE);
  localparam longint unsigned S1 = isqrt64((64'd1 << 61) / BLOCK_SIZE);

  function automatic tab_t build_tab();
    tab_t            tb;
    int              m;
    int              q;
    int              rr;
    logic            neg;
    longint unsigned c;
    longint unsigned mag;
    longint          v;
    for (int k = 0; k < BLOCK_SIZE; k++) begin
      for (int n = 0; n < BLOCK_SIZE; n++) begin
        m   = ((2 * n + 1) * k) % (4 * BLOCK_SIZE);
        q   = m / BLOCK_SIZE;
        rr  = m % BLOCK_SIZE;
        neg = (q == 1) || (q == 2);
        c   = longint'(cos_q30(((q == 1) || (q == 3)) ? BLOCK_SIZE - rr : rr));
        mag = c * ((k == 0) ? S0 : S1);
        v   = longint'((mag + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS));
        tb[k * BLOCK_SIZE + n] = COEF_W'(neg ? -v : v);
      end
    end
    return tb;
  endfunction

  localparam tab_t COS_TAB = build_tab();

  logic [AW-1:0] addr;

  assign addr = AW'(32'(row_idx) * BLOCK_SIZE + 32'(col_idx));

  always_ff @(posedge clk) begin
    if (en) begin
      coef <= COS_TAB[addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dct2d_mac.sv
// Shared multiply-accumulate unit: product register, accumulator, and the
// round/saturate of the finished sum. Uses dct2d_pkg for widths and the tag.
`default_nettype none

module dct2d_mac #(
  parameter int COEF_W         = 16,
  parameter int ACC_W          = 44,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire dct2d_pkg::mac_tag_t                    tag_in,
  input  wire logic signed [dct2d_pkg::PART_W-1:0]    op_in,
  input  wire logic signed [COEF_W-1:0]               coef_in,
  output dct2d_pkg::mac_tag_t                         tag_out,
  output logic signed [dct2d_pkg::PART_W-1:0]         part_sat,
  output logic signed [dct2d_pkg::OUT_W-1:0]          res_sat
);

  import dct2d_pkg::*;

  localparam int PW = PART_W + COEF_W;
  localparam int S1 = COEF_FRAC_BITS - PART_FRAC;
  localparam int S2 = COEF_FRAC_BITS + PART_FRAC;

  localparam logic signed [ACC_W:0] RND1 = (ACC_W+1)'(64'd1 << (S1 - 1));
  localparam logic signed [ACC_W:0] RND2 = (ACC_W+1)'(64'd1 << (S2 - 1));
  localparam logic signed [ACC_W:0] P_HI = (ACC_W+1)'((64'd1 << (PART_W - 1)) - 64'd1);
  localparam logic signed [ACC_W:0] P_LO = ~P_HI;
  localparam logic signed [ACC_W:0] R_HI = (ACC_W+1)'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [ACC_W:0] R_LO = ~R_HI;

  mac_tag_t                 tag2_r;
  mac_tag_t                 tag3_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W:0]    acc_x;
  logic signed [ACC_W:0]    sum1;
  logic signed [ACC_W:0]    sum2;
  logic signed [ACC_W:0]    shr1;
  logic signed [ACC_W:0]    shr2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag2_r <= tag_in;
      tag3_r <= tag2_r;
    end
  end

  // restart the sum on the first term of each dot product
  assign acc_nxt = (tag2_r.first ? {ACC_W{1'b0}} : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_in * coef_in;
      if (tag2_r.valid) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // round half up, then clamp
  assign acc_x = {acc_r[ACC_W-1], acc_r};
  assign sum1  = acc_x + RND1;
  assign sum2  = acc_x + RND2;
  assign shr1  = sum1 >>> S1;
  assign shr2  = sum2 >>> S2;

  always_comb begin
    if (shr1 > P_HI) begin
      part_sat = PART_W'(P_HI);
    end else if (shr1 < P_LO) begin
      part_sat = PART_W'(P_LO);
    end else begin
      part_sat = shr1[PART_W-1:0];
    end
    if (shr2 > R_HI) begin
      res_sat = OUT_W'(R_HI);
    end else if (shr2 < R_LO) begin
      res_sat = OUT_W'(R_LO);
    end else begin
      res_sat = shr2[OUT_W-1:0];
    end
  end

  assign tag_out = tag3_r;

endmodule

`default_nettype wire

>>> tb/block_dct_idct_2d_tb.sv
// Testbench for block_dct_idct_2d: streams 8x8 sample blocks in both directions
// and checks every transformed value against an in-bench fixed-point transform.
// Depends on dct2d_pkg and the block's RTL.
`timescale 1ns / 1ps

module block_dct_idct_2d_tb;

  localparam int BS       = 8;
  localparam int NSQ      = BS * BS;
  localparam int CFB      = 14;
  localparam int SMP_W    = dct2d_pkg::SAMPLE_W;
  localparam int RES_W    = dct2d_pkg::OUT_W;
  localparam int HOLD_LEN = 2500;
  localparam int DRAIN_CAP = 20000;

  typedef enum bit {
    DIR_FORWARD = 1'b0,
    DIR_INVERSE = 1'b1
  } dct_dir_t;

  typedef enum int {
    BLK_RANDOM,
    BLK_ALL_MAX,
    BLK_CHECKER
  } block_style_t;

  typedef struct {
    logic signed [RES_W-1:0] value;
    logic                    last;
  } dct_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SMP_W-1:0] in_sample_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [RES_W-1:0] out_value;
  logic                    out_block_last;
  logic                    cfg_wr_en = 1'b0;
  logic                    cfg_wr_data = 1'b0;

  block_dct_idct_2d dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_value(in_sample_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_block_last (out_block_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // transform state mirrored in the bench
  longint                  coef_tab [BS][BS];
  logic signed [SMP_W-1:0] sample_buf [NSQ];
  int                      load_idx;
  dct_dir_t                dir_shadow;
  dct_result_t             pending_results [$];

  int  mismatch_count;
  int  results_checked;
  int  blocks_fwd;
  int  blocks_inv;
  bit  no_idle;
  int  sink_hold_len;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d values still outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- cosine table

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned probe;
    r = 0;
    probe = 64'd1 << 62;
    while (probe > v)
      probe >>= 2;
    while (probe != 0) begin
      if (v >= r + probe) begin
        v = v - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r >>= 1;
      end
      probe >>= 2;
    end
    return r;
  endfunction

  // cos(pi*t/(2*BS)) with 30 fraction bits, Taylor series in Horner form
  function automatic longint cos_fix30(int unsigned t);
    longint q30;
    longint x;
    longint x2;
    longint r;
    q30 = longint'(1) << 30;
    x = longint'((64'd3373259426 * t) / (2 * BS));
    x2 = (x * x) / q30;
    r = q30;
    for (int i = 10; i >= 1; i--)
      r = q30 - ((x2 * r) / q30) / longint'((2 * i - 1) * (2 * i));
    if (r < 0)
      r = 0;
    if (r > q30)
      r = q30;
    return r;
  endfunction

  function automatic void build_coef_tab();
    longint unsigned s0;
    longint unsigned s1;
    longint unsigned c;
    longint unsigned mag;
    longint          v;
    int unsigned     m;
    int unsigned     q;
    int unsigned     rr;
    s0 = int_sqrt((64'd1 << 60) / BS);
    s1 = int_sqrt((64'd1 << 61) / BS);
    for (int k = 0; k < BS; k++) begin
      for (int n = 0; n < BS; n++) begin
        m = ((2 * n + 1) * k) % (4 * BS);
        q = m / BS;
        rr = m % BS;
        c = cos_fix30((q == 1 || q == 3) ? BS - rr : rr);
        mag = c * ((k == 0) ? s0 : s1);
        v = longint'((mag + (64'd1 << (59 - CFB))) >> (60 - CFB));
        coef_tab[k][n] = (q == 1 || q == 2) ? -v : v;
      end
    end
  endfunction

  // ---------------------------------------------------------------- transform

  function automatic longint basis(int r, int c, bit transpose);
    return transpose ? coef_tab[c][r] : coef_tab[r][c];
  endfunction

  // round half up, then floor shift
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic void transform_block(dct_dir_t dir);
    longint      partial [NSQ];
    longint      acc;
    bit          inv;
    dct_result_t res;
    inv = (dir == DIR_INVERSE);
    // column pass
    for (int a = 0; a < BS; a++) begin
      for (int b = 0; b < BS; b++) begin
        acc = 0;
        for (int i = 0; i < BS; i++)
          acc += basis(a, i, inv) * longint'(sample_buf[i * BS + b]);
        partial[a * BS + b] = clamp_signed(round_shr(acc, CFB - 4), 24);
      end
    end
    // row pass
    for (int a = 0; a < BS; a++) begin
      for (int b = 0; b < BS; b++) begin
        acc = 0;
        for (int i = 0; i < BS; i++)
          acc += partial[a * BS + i] * basis(i, b, !inv);
        res.value = RES_W'(clamp_signed(round_shr(acc, CFB + 4), RES_W));
        res.last  = (a * BS + b == NSQ - 1);
        pending_results.push_back(res);
      end
    end
    if (inv)
      blocks_inv++;
    else
      blocks_fwd++;
  endfunction

  function automatic void absorb_sample(logic signed [SMP_W-1:0] v);
    sample_buf[load_idx] = v;
    load_idx++;
    if (load_idx == NSQ) begin
      load_idx = 0;
      transform_block(dir_shadow);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string what, input int idx,
                                 input int got, input int want);
    mismatch_count++;
    $display("ERROR %0t: %s at %0d: got %0d, want %0d", $realtime, what, idx, got, want);
  endtask

  // Caller stands at a rising edge. On return the sample was just taken and
  // in_valid is still high: send again or release in this same step.
  task automatic send_sample(input logic signed [SMP_W-1:0] v);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    absorb_sample(v);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_direction(input dct_dir_t dir);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dir;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    dir_shadow = dir;
    @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3, 4: return SMP_W'($urandom_range(0, 255));
      5, 6:    return SMP_W'(int'($urandom_range(0, 128)) - 64);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_block(input block_style_t style);
    logic signed [SMP_W-1:0] v;
    for (int k = 0; k < NSQ; k++) begin
      case (style)
        BLK_ALL_MAX: v = 16'sh7fff;
        BLK_CHECKER: v = (((k / BS) + (k % BS)) % 2 == 0) ? 16'sh7fff : 16'sh8000;
        default:     v = pick_sample();
      endcase
      send_sample(v);
    end
  endtask

  // wait for every outstanding value, then let the pipeline settle
  task automatic wait_drained();
    int cnt;
    cnt = 0;
    while (pending_results.size() != 0 && cnt < DRAIN_CAP) begin
      @(posedge clk);
      cnt++;
    end
    if (pending_results.size() != 0)
      report_mismatch("values never produced", pending_results.size(), 0, 0);
    repeat (20) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : sink_ready_gen
    int burst;
    int hold_cnt;
    @(posedge clk);
    forever begin
      if (sink_hold_len > 0) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < sink_hold_len; hold_cnt++)
          @(posedge clk);
        sink_hold_len = 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 15);
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        burst = $urandom_range(1, 20);
        repeat (burst) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dct_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected value", results_checked, out_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value)
          report_mismatch("out_value", results_checked, out_value, want.value);
        if (out_block_last !== want.last)
          report_mismatch("out_block_last", results_checked, out_block_last, want.last);
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------- tests

  // the value held when the last sample lands decides the whole block
  task automatic test_mid_block_direction();
    set_direction(DIR_FORWARD);
    for (int k = 0; k < 30; k++)
      send_sample(pick_sample());
    release_input();
    set_direction(DIR_INVERSE);
    for (int k = 30; k < NSQ; k++)
      send_sample(pick_sample());
    release_input();
    wait_drained();
  endtask

  // stall the result side long enough that the block stops taking samples;
  // the first block saturates every forward output it can
  task automatic test_backpressure();
    set_direction(DIR_FORWARD);
    sink_hold_len = HOLD_LEN;
    send_block(BLK_ALL_MAX);
    send_block(BLK_RANDOM);
    release_input();
    wait_drained();
  endtask

  // extreme inverse coefficients with no idle cycles on either side
  task automatic test_full_rate();
    no_idle = 1'b1;
    set_direction(DIR_INVERSE);
    send_block(BLK_CHECKER);
    release_input();
    wait_drained();
  endtask

  initial begin
    mismatch_count  = 0;
    results_checked = 0;
    blocks_fwd      = 0;
    blocks_inv      = 0;
    no_idle         = 1'b0;
    sink_hold_len   = 0;
    load_idx        = 0;
    dir_shadow      = DIR_FORWARD;
    build_coef_tab();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_mid_block_direction();
    test_backpressure();
    test_full_rate();

    repeat (40) @(posedge clk);
    $display("Covered %0d forward and %0d inverse blocks, %0d values checked,",
             blocks_fwd, blocks_inv, results_checked);
    $display("including output saturation, a mid-block mode switch and a long output stall.");
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
